### design/bhp_pkg.sv
// ----------------------------------------------------------------------------
// Bucket histogram package
// Shared constants, operation codes and beat types for the bucket histogram
// with percentile query.
// ----------------------------------------------------------------------------
package bhp_pkg;

    localparam int DEF_NUM_BUCKETS = 16;
    localparam int DEF_COUNT_WIDTH = 32;

    localparam int CFG_W    = 5;
    localparam int ADDR_W   = 3;
    localparam int PCT_W    = 7;

    localparam logic [CFG_W-1:0] BUCKETS_RESET = 5'd16;

    localparam logic [0:0] REG_BUCKETS_IN_USE = 1'b0;

    localparam logic [2:0] MODE_LOAD    = 3'd0;
    localparam logic [2:0] MODE_COLLECT = 3'd1;
    localparam logic [2:0] MODE_DISCARD = 3'd2;
    localparam logic [2:0] MODE_QUERY   = 3'd3;
    localparam logic [2:0] MODE_CLEAR   = 3'd4;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [63:0] sample_value;
        logic [3:0]         bucket_index;
        logic [PCT_W-1:0]   percent;
    } bhp_in_t;

    typedef struct packed {
        logic signed [63:0] result_value;
        logic               bucket_found;
        logic [3:0]         found_index;
        logic [1:0]         status;
    } bhp_out_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [63:0] value;
        logic [3:0]         index;
        logic               hit;
        logic [3:0]         fidx;
        logic [1:0]         status;
        logic signed [63:0] res;
    } bhp_beat_t;

endpackage

### design/bhp_cell.sv
// ----------------------------------------------------------------------------
// Histogram cell
// Holds one bucket bound and its count, acts on the beat passing through and
// registers it on to the next cell.
// ----------------------------------------------------------------------------
module bhp_cell #(
    parameter int COUNT_WIDTH = bhp_pkg::DEF_COUNT_WIDTH,
    parameter int ACC_W       = bhp_pkg::DEF_COUNT_WIDTH + 11,
    parameter int N_W         = 5,
    parameter int CELL_ID     = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [N_W-1:0]      n_active_i,
    input  logic [ACC_W-1:0]    thr_i,
    input  logic                in_valid,
    input  bhp_pkg::bhp_beat_t  in_beat,
    input  logic [ACC_W-1:0]    in_acc,
    output logic                out_valid,
    output bhp_pkg::bhp_beat_t  out_beat,
    output logic [ACC_W-1:0]    out_acc
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = '1;
    localparam logic [3:0]             CELL_FIDX = 4'(CELL_ID);
    localparam bit                     ID_FITS   = (CELL_ID < 16);

    logic signed [63:0]       bound_reg;
    logic [COUNT_WIDTH-1:0]   count_reg;
    logic [COUNT_WIDTH-1:0]   count_next;
    logic                     valid_reg;
    bhp_pkg::bhp_beat_t       beat_reg;
    bhp_pkg::bhp_beat_t       beat_next;
    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         acc_next;
    logic [ACC_W-1:0]         count_x100;
    logic                     active;
    logic                     last;
    logic                     bound_we;

    assign active     = N_W'(CELL_ID) < n_active_i;
    assign last       = N_W'(CELL_ID + 1) == n_active_i;
    assign count_x100 = (ACC_W'(count_reg) << 6) + (ACC_W'(count_reg) << 5)
                      + (ACC_W'(count_reg) << 2);

    always_comb begin
        beat_next  = in_beat;
        count_next = count_reg;
        acc_next   = in_acc;
        bound_we   = 1'b0;
        if (in_valid) begin
            unique case (in_beat.mode)
                bhp_pkg::MODE_LOAD: begin
                    bound_we = ID_FITS && (in_beat.index == CELL_FIDX);
                end
                bhp_pkg::MODE_COLLECT: begin
                    if (active && !in_beat.hit && (in_beat.value <= bound_reg)) begin
                        beat_next.hit  = 1'b1;
                        beat_next.fidx = CELL_FIDX;
                        if (count_reg == CNT_MAX) begin
                            beat_next.status = bhp_pkg::STATUS_OVERFLOW;
                        end else begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                bhp_pkg::MODE_DISCARD: begin
                    if (active && !in_beat.hit && (in_beat.value <= bound_reg)) begin
                        beat_next.hit  = 1'b1;
                        beat_next.fidx = CELL_FIDX;
                        if (count_reg == '0) begin
                            beat_next.status = bhp_pkg::STATUS_UNDERFLOW;
                        end else begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
                bhp_pkg::MODE_QUERY: begin
                    if (active) begin
                        acc_next = in_acc + count_x100;
                        if (!in_beat.hit && (acc_next > thr_i)) begin
                            beat_next.hit = 1'b1;
                            beat_next.res = bound_reg;
                        end
                    end
                end
                bhp_pkg::MODE_CLEAR: begin
                    count_next = '0;
                    if (last) begin
                        beat_next.res = bound_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            count_reg <= '0;
        end else begin
            valid_reg <= in_valid;
            count_reg <= count_next;
        end
        beat_reg <= beat_next;
        acc_reg  <= acc_next;
        if (bound_we) begin
            bound_reg <= in_beat.value;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;
    assign out_acc   = acc_reg;

endmodule

### design/bucket_histogram_percentile.sv
// An accepted beat passes the entry register, each cell register of the chain
// and the pending register before it reaches the output register and m_valid.
// A new item is taken only after the last result moves to the output register.
// Reset clears all counts, the total, the largest sample and the cell chain,
// and sets buckets_in_use to 16; bucket bounds are not reset.
// ----------------------------------------------------------------------------
// Bucket histogram with percentile query
// Entry stage for total and largest sample, a chain of bucket cells, and a
// result stage with an output register, plus the APB register port.
// ----------------------------------------------------------------------------
module bucket_histogram_percentile #(
    parameter int NUM_BUCKETS = bhp_pkg::DEF_NUM_BUCKETS,
    parameter int COUNT_WIDTH = bhp_pkg::DEF_COUNT_WIDTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  bhp_pkg::bhp_in_t             s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output bhp_pkg::bhp_out_t            m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bhp_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int N_W   = $clog2(NUM_BUCKETS + 1);
    localparam int THR_W = COUNT_WIDTH + bhp_pkg::PCT_W;
    localparam int ACC_W = COUNT_WIDTH + $clog2(NUM_BUCKETS) + bhp_pkg::PCT_W;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [bhp_pkg::CFG_W-1:0] biu_reg;
    logic [N_W-1:0]            n_active;
    logic [COUNT_WIDTH-1:0]    total_reg;
    logic [COUNT_WIDTH-1:0]    total_next;
    logic signed [63:0]        largest_reg;
    logic [ACC_W-1:0]          thr_reg;
    logic                      entry_valid_reg;
    bhp_pkg::bhp_beat_t        entry_beat_reg;
    logic [1:0]                entry_status;
    logic                      busy_reg;
    logic                      pend_valid_reg;
    bhp_pkg::bhp_out_t         pend_reg;
    bhp_pkg::bhp_out_t         tail_out;
    logic                      m_valid_reg;
    bhp_pkg::bhp_out_t         m_data_reg;
    logic                      accept;
    logic                      cfg_write;
    logic                      out_load;

    logic [NUM_BUCKETS-1:0]    cell_valid;
    bhp_pkg::bhp_beat_t        cell_beat [NUM_BUCKETS];
    logic [ACC_W-1:0]          cell_acc  [NUM_BUCKETS];
    bhp_pkg::bhp_beat_t        tail_beat;
    logic                      tail_valid;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                    && (paddr[2] == bhp_pkg::REG_BUCKETS_IN_USE);

    always_comb begin
        unique case (paddr[2])
            bhp_pkg::REG_BUCKETS_IN_USE: prdata = 32'(biu_reg);
            default:                     prdata = '0;
        endcase
    end

    always_comb begin
        if (biu_reg == '0) begin
            n_active = N_W'(1);
        end else if (int'(biu_reg) > NUM_BUCKETS) begin
            n_active = N_W'(NUM_BUCKETS);
        end else begin
            n_active = N_W'(biu_reg);
        end
    end

    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;

    always_comb begin
        total_next   = total_reg;
        entry_status = bhp_pkg::STATUS_OK;
        unique case (s_data.mode)
            bhp_pkg::MODE_COLLECT: begin
                if (total_reg == CNT_MAX) begin
                    entry_status = bhp_pkg::STATUS_OVERFLOW;
                end else begin
                    total_next = total_reg + 1'b1;
                end
            end
            bhp_pkg::MODE_DISCARD: begin
                if (total_reg == '0) begin
                    entry_status = bhp_pkg::STATUS_UNDERFLOW;
                end else begin
                    total_next = total_reg - 1'b1;
                end
            end
            bhp_pkg::MODE_CLEAR: begin
                total_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            biu_reg         <= bhp_pkg::BUCKETS_RESET;
            total_reg       <= '0;
            largest_reg     <= '0;
            entry_valid_reg <= 1'b0;
            busy_reg        <= 1'b0;
            pend_valid_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_write) begin
                biu_reg <= pwdata[bhp_pkg::CFG_W-1:0];
            end
            entry_valid_reg <= accept;
            if (accept) begin
                total_reg <= total_next;
                busy_reg  <= 1'b1;
            end
            if (accept && (s_data.mode == bhp_pkg::MODE_COLLECT)
                && (s_data.sample_value > largest_reg)) begin
                largest_reg <= s_data.sample_value;
            end else if (tail_valid && (tail_beat.mode == bhp_pkg::MODE_CLEAR)) begin
                largest_reg <= tail_beat.res;
            end
            if (tail_valid) begin
                pend_valid_reg <= 1'b1;
            end else if (out_load) begin
                pend_valid_reg <= 1'b0;
                busy_reg       <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            entry_beat_reg.mode   <= s_data.mode;
            entry_beat_reg.value  <= s_data.sample_value;
            entry_beat_reg.index  <= s_data.bucket_index;
            entry_beat_reg.hit    <= 1'b0;
            entry_beat_reg.fidx   <= '0;
            entry_beat_reg.status <= entry_status;
            entry_beat_reg.res    <= '0;
            thr_reg <= ACC_W'(THR_W'(total_reg) * THR_W'(s_data.percent));
        end
        if (tail_valid) begin
            pend_reg <= tail_out;
        end
        if (out_load) begin
            m_data_reg <= pend_reg;
        end
    end

    assign out_load = pend_valid_reg && (!m_valid_reg || m_ready);

    for (genvar i = 0; i < NUM_BUCKETS; i++) begin : g_cell
        if (i == 0) begin : g_head
            bhp_cell #(
                .COUNT_WIDTH (COUNT_WIDTH),
                .ACC_W       (ACC_W),
                .N_W         (N_W),
                .CELL_ID     (i)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .n_active_i (n_active),
                .thr_i      (thr_reg),
                .in_valid   (entry_valid_reg),
                .in_beat    (entry_beat_reg),
                .in_acc     ('0),
                .out_valid  (cell_valid[i]),
                .out_beat   (cell_beat[i]),
                .out_acc    (cell_acc[i])
            );
        end else begin : g_body
            bhp_cell #(
                .COUNT_WIDTH (COUNT_WIDTH),
                .ACC_W       (ACC_W),
                .N_W         (N_W),
                .CELL_ID     (i)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .n_active_i (n_active),
                .thr_i      (thr_reg),
                .in_valid   (cell_valid[i-1]),
                .in_beat    (cell_beat[i-1]),
                .in_acc     (cell_acc[i-1]),
                .out_valid  (cell_valid[i]),
                .out_beat   (cell_beat[i]),
                .out_acc    (cell_acc[i])
            );
        end
    end

    assign tail_valid = cell_valid[NUM_BUCKETS-1];
    assign tail_beat  = cell_beat[NUM_BUCKETS-1];

    always_comb begin
        tail_out = '0;
        unique case (tail_beat.mode)
            bhp_pkg::MODE_COLLECT, bhp_pkg::MODE_DISCARD: begin
                tail_out.bucket_found = tail_beat.hit;
                tail_out.found_index  = tail_beat.fidx;
                tail_out.status       = tail_beat.status;
            end
            bhp_pkg::MODE_QUERY: begin
                tail_out.result_value = tail_beat.hit ? tail_beat.res : largest_reg;
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Only one beat may be anywhere between entry and the pending result.
    a_single_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({pend_valid_reg, entry_valid_reg, cell_valid}))
        else $error("more than one beat in flight");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> ({pend_valid_reg, entry_valid_reg, cell_valid} == '0))
        else $error("beat in flight while the block reports idle");

    a_pend_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> busy_reg)
        else $error("pending result without an item in progress");

    a_total_source: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (total_reg != $past(total_reg))) |-> $past(accept))
        else $error("sample total changed without an accepted beat");

endmodule
